FILE: src/sac_pkg.sv
`default_nettype none

package sac_pkg;

    // Register indexes of the configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAY_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_SHIFT = 2'd2;

    // Command codes of the input transaction
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Replacement policy codes
    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    // Largest size shift that takes effect, and largest total index shift
    localparam logic [2:0] SIZE_SHIFT_MAX = 3'd4;
    localparam int         MAX_SHIFT      = 7;

    localparam int SET_NUM_W = 10;
    localparam int COUNT_W   = 32;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic hit;
        logic wr_en;
    } upd_status_t;

endpackage

`default_nettype wire

FILE: src/sac_tag_mem.sv
`default_nettype none

module sac_tag_mem #(
    parameter int ROW_W  = 7,
    parameter int DATA_W = 208
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ROW_W-1:0]  rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    output logic                   rd_live,
    input  wire logic              wr_en,
    input  wire logic [ROW_W-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              clr_all
);

    localparam int ROWS = 2 ** ROW_W;

    logic [DATA_W-1:0] ram_reg [ROWS];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ROWS-1:0]   live_reg;
    logic              rd_live_reg;

    // Row store: one registered read port, one write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    // A row that was never written since the last clear reads as all invalid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg    <= '0;
            rd_live_reg <= 1'b0;
        end else begin
            if (clr_all) begin
                live_reg <= '0;
            end else if (wr_en) begin
                live_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_live_reg <= live_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_live = rd_live_reg;

endmodule

`default_nettype wire

FILE: src/sac_row_update.sv
`default_nettype none

module sac_row_update #(
    parameter int TAG_W  = 25,
    parameter int LANES  = 8,
    parameter int LANE_W = 3
) (
    input  wire logic [LANES-1:0][TAG_W-1:0] tags_in,
    input  wire logic [LANES-1:0]            valid_in,
    input  wire logic                        row_live,
    input  wire logic [TAG_W-1:0]            tag,
    input  wire logic [LANE_W-1:0]           first,
    input  wire logic [LANE_W-1:0]           last,
    input  wire logic                        policy,
    output logic      [LANES-1:0][TAG_W-1:0] tags_out,
    output logic      [LANES-1:0]            valid_out,
    output sac_pkg::upd_status_t             status
);

    import sac_pkg::*;

    logic [LANES-1:0]            vld;
    logic [LANES-1:0]            match;
    logic [LANES-1:0][TAG_W-1:0] up_tag;
    logic [LANES-1:0]            up_vld;
    logic [LANE_W-1:0]           hit_pos;
    logic [LANE_W-1:0]           start;
    logic                        hit;

    assign vld = valid_in & {LANES{row_live}};

    for (genvar w = 0; w < LANES; w++) begin : g_lane
        assign match[w] = (LANE_W'(w) >= first) && (LANE_W'(w) <= last) &&
                          vld[w] && (tags_in[w] == tag);
        // Neighbor toward the newest end, used when the set shifts down
        if (w < LANES - 1) begin : g_up
            assign up_tag[w] = tags_in[w+1];
            assign up_vld[w] = vld[w+1];
        end else begin : g_top
            assign up_tag[w] = tags_in[w];
            assign up_vld[w] = vld[w];
        end
    end

    // Oldest matching slot wins
    always_comb begin
        hit_pos = '0;
        for (int w = LANES - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_pos = LANE_W'(w);
            end
        end
    end

    assign hit   = |match;
    assign start = hit ? hit_pos : first;

    always_comb begin
        for (int w = 0; w < LANES; w++) begin
            if (LANE_W'(w) == last) begin
                tags_out[w]  = tag;
                valid_out[w] = 1'b1;
            end else if ((LANE_W'(w) >= start) && (LANE_W'(w) < last)) begin
                tags_out[w]  = up_tag[w];
                valid_out[w] = up_vld[w];
            end else begin
                tags_out[w]  = tags_in[w];
                valid_out[w] = vld[w];
            end
        end
    end

    assign status.hit   = hit;
    assign status.wr_en = !hit || (policy == POLICY_LRU);

endmodule

`default_nettype wire

FILE: src/set_assoc_cache_hit_miss_sim_unit.sv
`default_nettype none

// Tag-only set-associative cache model with LRU or FIFO replacement. Each
// transaction on the s_ channel is either an access at a byte address or a
// clear that invalidates every slot and zeroes the access and miss counts;
// each yields exactly one result on the m_ channel (hit flag, set index and
// the saturating totals after this transaction). Blocks are 2**OFFSET_BITS
// bytes, capacity is MAX_BLOCKS blocks shifted down by size_shift (capped at
// four) and the set holds 2**way_shift ways, capped at MAX_WAYS. Slots live in
// a single-port-read row memory of MAX_BLOCKS/MAX_WAYS rows; every set fits in
// one row, so one read and one write-back serve an access. A transaction has
// two steps: the registered memory read, then the compare, age shift and
// write-back. The next transaction is accepted in the cycle after
// write-back, so a following access to the same set always sees the updated
// row. A result may sit in the output register while the next transaction is
// read; the write-back waits only if that result is still not taken. Clear
// takes effect at once through per-row live flags, with no sweep of the
// memory. Write configuration only while no transaction is in flight.
// MAX_BLOCKS and MAX_WAYS must be powers of two.
module set_assoc_cache_hit_miss_sim_unit #(
    parameter int ADDR_BITS   = 32,
    parameter int OFFSET_BITS = 4,
    parameter int MAX_BLOCKS  = 1024,
    parameter int MAX_WAYS    = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sac_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input transactions
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_command,
    input  wire logic [31:0]                    s_address,
    // results
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_hit,
    output logic [sac_pkg::SET_NUM_W-1:0]       m_set_number,
    output logic [sac_pkg::COUNT_W-1:0]         m_access_total,
    output logic [sac_pkg::COUNT_W-1:0]         m_miss_total
);

    import sac_pkg::*;

    // Geometry derived from the parameters
    localparam int IBITS    = $clog2(MAX_BLOCKS);
    localparam int LW       = $clog2(MAX_WAYS);
    localparam int LANE_W   = (LW > 0) ? LW : 1;
    localparam int WAYS_W   = LW + 1;
    localparam int ROW_W    = IBITS - LW;
    localparam int SB_W     = $clog2(IBITS + 1);
    localparam int BLK_W    = ADDR_BITS - OFFSET_BITS;
    localparam int EXT_W    = (BLK_W > IBITS) ? BLK_W : IBITS;
    localparam int MIN_SET  = (IBITS > MAX_SHIFT) ? IBITS - MAX_SHIFT : 0;
    localparam int TAG_RAW  = BLK_W - MIN_SET;
    localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int DATA_W   = MAX_WAYS * (TAG_W + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration registers
    logic       policy_reg;
    logic [1:0] way_shift_reg;
    logic [2:0] size_shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg     <= POLICY_LRU;
            way_shift_reg  <= '0;
            size_shift_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_POLICY:     policy_reg     <= cfg_wdata[0];
                CFG_WAY_SHIFT:  way_shift_reg  <= cfg_wdata[1:0];
                CFG_SIZE_SHIFT: size_shift_reg <= cfg_wdata[2:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // Address decode on the incoming transaction
    logic [63:0]            addr64;
    logic [ADDR_BITS-1:0]   addr_w;
    logic [EXT_W-1:0]       blk;
    logic [2:0]             ss;
    logic [3:0]             shift;
    logic [SB_W-1:0]        set_bits;
    logic [IBITS-1:0]       set_mask;
    logic [IBITS-1:0]       set_idx;
    logic [2:0]             wsh_eff;
    logic [WAYS_W-1:0]      ways;
    logic [IBITS-1:0]       base;
    logic [LANE_W-1:0]      lane;
    logic [WAYS_W-1:0]      last_sum;
    logic [TAG_W-1:0]       tag;

    assign addr64   = {32'b0, s_address};
    assign addr_w   = addr64[ADDR_BITS-1:0];
    assign blk      = EXT_W'(addr_w >> OFFSET_BITS);
    assign ss       = (size_shift_reg > SIZE_SHIFT_MAX) ? SIZE_SHIFT_MAX : size_shift_reg;
    assign shift    = {1'b0, ss} + {2'b0, way_shift_reg};
    assign set_bits = (int'(shift) >= IBITS) ? '0 : SB_W'(IBITS - int'(shift));
    assign set_mask = ~({IBITS{1'b1}} << set_bits);
    assign set_idx  = blk[IBITS-1:0] & set_mask;
    assign tag      = TAG_W'(blk >> set_bits);
    assign wsh_eff  = (int'(way_shift_reg) > LW) ? 3'(LW) : {1'b0, way_shift_reg};
    assign ways     = WAYS_W'(1) << wsh_eff;
    assign base     = set_idx << wsh_eff;
    assign lane     = LANE_W'(base & IBITS'(MAX_WAYS - 1));
    assign last_sum = WAYS_W'(lane) + ways - WAYS_W'(1);

    // Handshake control
    state_t state_reg, state_next;
    logic   accept;
    logic   lookup_fire;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid)     state_next = ST_LOOKUP;
            ST_LOOKUP: if (lookup_fire) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        lookup_fire = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready     = 1'b1;
            // hold the write-back until the output register is free
            ST_LOOKUP: lookup_fire = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid_next = lookup_fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Decoded transaction held for the lookup cycle
    logic                 cmd_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [LANE_W-1:0]    first_reg;
    logic [LANE_W-1:0]    last_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [SET_NUM_W-1:0] set_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= s_command;
            tag_reg   <= tag;
            first_reg <= lane;
            last_reg  <= LANE_W'(last_sum);
            row_reg   <= base[IBITS-1:LW];
            set_reg   <= SET_NUM_W'(set_idx);
        end
    end

    // Row memory
    logic [DATA_W-1:0]             rd_data;
    logic                          rd_live;
    logic [DATA_W-1:0]             wr_data;
    logic                          mem_wr_en;
    logic                          clr_all;
    logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tags;
    logic [MAX_WAYS-1:0]           rd_valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0] new_tags;
    logic [MAX_WAYS-1:0]           new_valid;
    upd_status_t                   status;

    sac_tag_mem #(
        .ROW_W  (ROW_W),
        .DATA_W (DATA_W)
    ) u_tag_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (base[IBITS-1:LW]),
        .rd_data (rd_data),
        .rd_live (rd_live),
        .wr_en   (mem_wr_en),
        .wr_addr (row_reg),
        .wr_data (wr_data),
        .clr_all (clr_all)
    );

    assign rd_tags  = rd_data[MAX_WAYS*TAG_W-1:0];
    assign rd_valid = rd_data[DATA_W-1 -: MAX_WAYS];

    sac_row_update #(
        .TAG_W  (TAG_W),
        .LANES  (MAX_WAYS),
        .LANE_W (LANE_W)
    ) u_row_update (
        .tags_in   (rd_tags),
        .valid_in  (rd_valid),
        .row_live  (rd_live),
        .tag       (tag_reg),
        .first     (first_reg),
        .last      (last_reg),
        .policy    (policy_reg),
        .tags_out  (new_tags),
        .valid_out (new_valid),
        .status    (status)
    );

    assign wr_data   = {new_valid, new_tags};
    // FIFO hits leave the row untouched; clear writes nothing
    assign mem_wr_en = lookup_fire && (cmd_reg == CMD_ACCESS) && status.wr_en;
    assign clr_all   = lookup_fire && (cmd_reg == CMD_CLEAR);

    // Saturating counters
    logic [COUNT_W-1:0] access_cnt_reg, access_cnt_next;
    logic [COUNT_W-1:0] miss_cnt_reg, miss_cnt_next;

    always_comb begin
        access_cnt_next = access_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        if (cmd_reg == CMD_CLEAR) begin
            access_cnt_next = '0;
            miss_cnt_next   = '0;
        end else begin
            if (access_cnt_reg != COUNT_MAX) begin
                access_cnt_next = access_cnt_reg + COUNT_W'(1);
            end
            if (!status.hit && (miss_cnt_reg != COUNT_MAX)) begin
                miss_cnt_next = miss_cnt_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            access_cnt_reg <= '0;
            miss_cnt_reg   <= '0;
        end else if (lookup_fire) begin
            access_cnt_reg <= access_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
        end
    end

    // Output register
    logic                 m_hit_reg;
    logic [SET_NUM_W-1:0] m_set_reg;
    logic [COUNT_W-1:0]   m_access_reg;
    logic [COUNT_W-1:0]   m_miss_reg;

    always_ff @(posedge aclk) begin
        if (lookup_fire) begin
            if (cmd_reg == CMD_CLEAR) begin
                m_hit_reg <= 1'b0;
                m_set_reg <= '0;
            end else begin
                m_hit_reg <= status.hit;
                m_set_reg <= set_reg;
            end
            m_access_reg <= access_cnt_next;
            m_miss_reg   <= miss_cnt_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_set_number   = m_set_reg;
    assign m_access_total = m_access_reg;
    assign m_miss_total   = m_miss_reg;

endmodule

`default_nettype wire

FILE: src/sac_checker.sv
`default_nettype none

module sac_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_we,
    input wire logic [1:0]  cfg_index,
    input wire logic [2:0]  cfg_wdata,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_command,
    input wire logic [31:0] s_address,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_hit,
    input wire logic [9:0]  m_set_number,
    input wire logic [31:0] m_access_total,
    input wire logic [31:0] m_miss_total
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_hit) &&
            $stable(m_set_number) && $stable(m_access_total) && $stable(m_miss_total)))
        else $error("stalled result changed");

    // Misses never outrun accesses
    a_miss_le_access: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_miss_total <= m_access_total))
        else $error("miss total above access total");

    // Only a clear leaves the access total at zero, and its result is all zero
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_access_total == 32'd0)) |->
            (!m_hit && (m_miss_total == 32'd0) && (m_set_number == 10'd0)))
        else $error("clear result not zero");

    // One transaction in flight: ready drops after each accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted during lookup");

endmodule

bind set_assoc_cache_hit_miss_sim_unit sac_checker u_sac_checker (.*);

`default_nettype wire
